@@ hdl/epipolar_distance_check_core_macros.svh @@
// ----------------------------------------------------------------------------
// epipolar distance check assertion macros
// shared assertion forms for the core
// ----------------------------------------------------------------------------
`ifndef EPIPOLAR_DISTANCE_CHECK_CORE_MACROS_SVH
`define EPIPOLAR_DISTANCE_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define EDC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("edc assertion failed");

// next-cycle implication
`define EDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("edc assertion failed");

`endif

@@ hdl/edc_pkg.sv @@
// ----------------------------------------------------------------------------
// edc_pkg
// widths, register codes and helpers for the epipolar distance check
// ----------------------------------------------------------------------------
package edc_pkg;

   localparam int COEF_W        = 21;
   localparam int PT_W          = 16;
   localparam int PROD_W        = 38;
   localparam int LINE_W        = 39;
   localparam int MLINE_W       = 38;
   localparam int HALF_W        = 19;
   localparam int DP_W          = 56;
   localparam int DOT_W         = 58;
   localparam int MAG_W         = 57;
   localparam int MAG_LO_W      = 29;
   localparam int MAG_HI_W      = 28;
   localparam int NORM_W        = 77;
   localparam int SQ_W          = 114;
   localparam int SRCH_W        = 116;
   localparam int DIST_W        = 16;
   localparam int REG_W         = 63;
   localparam int CSR_IDX_W     = 3;
   localparam int NUM_REGS      = 6;
   localparam int FRONT_STAGES  = 6;
   localparam int SEARCH_STAGES = 16;
   localparam int PIPE_DEPTH    = FRONT_STAGES + SEARCH_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_F21_ROW0 = 3'd0,
      CSR_F21_ROW1 = 3'd1,
      CSR_F21_ROW2 = 3'd2,
      CSR_F12_ROW0 = 3'd3,
      CSR_F12_ROW1 = 3'd4,
      CSR_F12_ROW2 = 3'd5
   } edc_csr_type;

   // one signed coefficient of a packed matrix row
   function automatic logic signed [COEF_W-1:0] coef_of(input logic [REG_W-1:0] row,
                                                        input int k);
      coef_of = $signed(row[k*COEF_W +: COEF_W]);
   endfunction

endpackage

@@ hdl/epipolar_distance_check_core.sv @@
// an accepted req word passes the front stages, the search stages and the output register
// throughput: one word per cycle unless rsp stalls; the 16-stage distance search sets the depth
// a stalled rsp side freezes the whole pipeline, nothing is dropped or repeated
// reset clears all stage valid bits and the six matrix row registers to zero
// ----------------------------------------------------------------------------
// epipolar_distance_check_core
// symmetric epipolar distance of one point pair against two matrices
// ----------------------------------------------------------------------------
`include "epipolar_distance_check_core_macros.svh"

module epipolar_distance_check_core
   import edc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [4*PT_W-1:0]    req_tdata,  // first_x, first_y, second_x, second_y
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DIST_W-1:0]    rsp_tdata,  // max_distance
   output logic                 rsp_tuser,  // degenerate
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   logic [REG_W-1:0] row_ff [NUM_REGS];
   logic             v_ff   [PIPE_DEPTH];
   logic             advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) row_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (edc_csr_type'(csr_index))
            CSR_F21_ROW0: row_ff[0] <= csr_data;
            CSR_F21_ROW1: row_ff[1] <= csr_data;
            CSR_F21_ROW2: row_ff[2] <= csr_data;
            CSR_F12_ROW0: row_ff[3] <= csr_data;
            CSR_F12_ROW1: row_ff[4] <= csr_data;
            CSR_F12_ROW2: row_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the last word is held
   assign advance    = !v_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = v_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_DEPTH; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   logic [PT_W-1:0] x1, y1, x2, y2;
   assign x1 = req_tdata[0*PT_W +: PT_W];
   assign y1 = req_tdata[1*PT_W +: PT_W];
   assign x2 = req_tdata[2*PT_W +: PT_W];
   assign y2 = req_tdata[3*PT_W +: PT_W];

   logic [SQ_W-1:0]   sq1, sq2;
   logic [NORM_W-1:0] nrm1, nrm2;
   logic              fdeg1, fdeg2, sdeg1, sdeg2;
   logic [DIST_W-1:0] d1, d2;

   // line in image one from point two, measured at point one
   edc_front u_front1 (
      .clock (clock), .en (advance),
      .row0 (row_ff[3]), .row1 (row_ff[4]), .row2 (row_ff[5]),
      .px (x2), .py (y2), .ox (x1), .oy (y1),
      .sq (sq1), .norm (nrm1), .deg (fdeg1)
   );

   edc_front u_front2 (
      .clock (clock), .en (advance),
      .row0 (row_ff[0]), .row1 (row_ff[1]), .row2 (row_ff[2]),
      .px (x1), .py (y1), .ox (x2), .oy (y2),
      .sq (sq2), .norm (nrm2), .deg (fdeg2)
   );

   edc_search u_search1 (
      .clock (clock), .en (advance), .sq (sq1), .norm (nrm1), .deg_i (fdeg1),
      .dist_o (d1), .deg_o (sdeg1)
   );

   edc_search u_search2 (
      .clock (clock), .en (advance), .sq (sq2), .norm (nrm2), .deg_i (fdeg2),
      .dist_o (d2), .deg_o (sdeg2)
   );

   logic [DIST_W-1:0] max_ff;
   logic              deg_ff;
   logic              deg_in;

   assign deg_in = sdeg1 || sdeg2;

   always_ff @(posedge clock) begin
      if (advance) begin
         max_ff <= deg_in ? {DIST_W{1'b1}} : ((d1 > d2) ? d1 : d2);
         deg_ff <= deg_in;
      end
   end

   assign rsp_tdata = max_ff;
   assign rsp_tuser = deg_ff;

   `EDC_ASSERT_NOW(a_deg_max, rsp_tvalid && rsp_tuser, rsp_tdata == {DIST_W{1'b1}})
   `EDC_ASSERT_NOW(a_stall_blocks, rsp_tvalid && !rsp_tready, !req_tready)
   `EDC_ASSERT_NEXT(a_stall_holds_mid, rsp_tvalid && !rsp_tready,
                    $stable(v_ff[FRONT_STAGES]))
   `EDC_ASSERT_NEXT(a_valid_moves, req_tvalid && req_tready, v_ff[0])

endmodule

@@ hdl/edc_front.sv @@
// ----------------------------------------------------------------------------
// edc_front
// epipolar line, point-line dot product, line norm and squared dot
// ----------------------------------------------------------------------------
module edc_front
   import edc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [REG_W-1:0]  row0,
   input  logic [REG_W-1:0]  row1,
   input  logic [REG_W-1:0]  row2,
   input  logic [PT_W-1:0]   px,
   input  logic [PT_W-1:0]   py,
   input  logic [PT_W-1:0]   ox,
   input  logic [PT_W-1:0]   oy,
   output logic [SQ_W-1:0]   sq,
   output logic [NORM_W-1:0] norm,
   output logic              deg
);

   logic [REG_W-1:0] rows [3];
   assign rows[0] = row0;
   assign rows[1] = row1;
   assign rows[2] = row2;

   // stage 1: coefficient products
   logic signed [PROD_W-1:0] p0_ff [3];
   logic signed [PROD_W-1:0] p1_ff [3];
   logic signed [COEF_W-1:0] c2_ff [3];
   logic [PT_W-1:0]          ox1_ff, oy1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p0_ff[i] <= coef_of(rows[i], 0) * $signed({1'b0, px});
            p1_ff[i] <= coef_of(rows[i], 1) * $signed({1'b0, py});
            c2_ff[i] <= coef_of(rows[i], 2);
         end
         ox1_ff <= ox;
         oy1_ff <= oy;
      end
   end

   // stage 2: line coefficients
   logic signed [LINE_W-1:0] line_ff [3];
   logic [PT_W-1:0]          ox2_ff, oy2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            line_ff[i] <= LINE_W'(p0_ff[i]) + LINE_W'(p1_ff[i])
                        + (LINE_W'(c2_ff[i]) <<< 4);
         end
         ox2_ff <= ox1_ff;
         oy2_ff <= oy1_ff;
      end
   end

   // stage 3: dot partials and split squares of |a|, |b|
   logic [MLINE_W-1:0]       m_in [2];
   logic signed [DP_W-1:0]   dp0_ff, dp1_ff;
   logic signed [LINE_W-1:0] l2_ff;
   logic [2*HALF_W-1:0]      hh_ff [2];
   logic [2*HALF_W-1:0]      hl_ff [2];
   logic [2*HALF_W-1:0]      ll_ff [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         m_in[i] = line_ff[i][LINE_W-1] ? MLINE_W'(-line_ff[i]) : MLINE_W'(line_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp0_ff <= line_ff[0] * $signed({1'b0, ox2_ff});
         dp1_ff <= line_ff[1] * $signed({1'b0, oy2_ff});
         l2_ff  <= line_ff[2];
         for (int i = 0; i < 2; i++) begin
            hh_ff[i] <= m_in[i][MLINE_W-1:HALF_W] * m_in[i][MLINE_W-1:HALF_W];
            hl_ff[i] <= m_in[i][MLINE_W-1:HALF_W] * m_in[i][HALF_W-1:0];
            ll_ff[i] <= m_in[i][HALF_W-1:0] * m_in[i][HALF_W-1:0];
         end
      end
   end

   // stage 4: dot product and norm
   logic signed [DOT_W-1:0] dot_ff;
   logic [NORM_W-1:0]       norm4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dot_ff   <= DOT_W'(dp0_ff) + DOT_W'(dp1_ff) + (DOT_W'(l2_ff) <<< 4);
         norm4_ff <= (NORM_W'(hh_ff[0]) << (2*HALF_W)) + (NORM_W'(hl_ff[0]) << (HALF_W+1))
                   + NORM_W'(ll_ff[0])
                   + (NORM_W'(hh_ff[1]) << (2*HALF_W)) + (NORM_W'(hl_ff[1]) << (HALF_W+1))
                   + NORM_W'(ll_ff[1]);
      end
   end

   // stage 5: split square of |dot|
   logic [MAG_W-1:0]            a_in;
   logic [2*MAG_HI_W-1:0]       ahh_ff;
   logic [MAG_HI_W+MAG_LO_W-1:0] ahl_ff;
   logic [2*MAG_LO_W-1:0]       all_ff;
   logic [NORM_W-1:0]           norm5_ff;
   logic                        deg5_ff;

   assign a_in = dot_ff[DOT_W-1] ? MAG_W'(-dot_ff) : MAG_W'(dot_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ahh_ff   <= a_in[MAG_W-1:MAG_LO_W] * a_in[MAG_W-1:MAG_LO_W];
         ahl_ff   <= a_in[MAG_W-1:MAG_LO_W] * a_in[MAG_LO_W-1:0];
         all_ff   <= a_in[MAG_LO_W-1:0] * a_in[MAG_LO_W-1:0];
         norm5_ff <= norm4_ff;
         deg5_ff  <= (norm4_ff == '0);
      end
   end

   // stage 6: dot squared
   logic [SQ_W-1:0]   sq_ff;
   logic [NORM_W-1:0] norm6_ff;
   logic              deg6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= (SQ_W'(ahh_ff) << (2*MAG_LO_W)) + (SQ_W'(ahl_ff) << (MAG_LO_W+1))
                   + SQ_W'(all_ff);
         norm6_ff <= norm5_ff;
         deg6_ff  <= deg5_ff;
      end
   end

   assign sq   = sq_ff;
   assign norm = norm6_ff;
   assign deg  = deg6_ff;

endmodule

@@ hdl/edc_search.sv @@
// ----------------------------------------------------------------------------
// edc_search
// largest d with d*d*norm <= sq, one result bit per stage
// ----------------------------------------------------------------------------
module edc_search
   import edc_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   sq,
   input  logic [NORM_W-1:0] norm,
   input  logic              deg_i,
   output logic [DIST_W-1:0] dist_o,
   output logic              deg_o
);

   // p holds d*d*norm, q holds d*norm
   logic [SRCH_W-1:0] p_ff [SEARCH_STAGES];
   logic [SRCH_W-1:0] q_ff [SEARCH_STAGES];
   logic [DIST_W-1:0] d_ff [SEARCH_STAGES];
   logic [SQ_W-1:0]   s_ff [SEARCH_STAGES];
   logic [NORM_W-1:0] n_ff [SEARCH_STAGES];
   logic              g_ff [SEARCH_STAGES];

   for (genvar j = 0; j < SEARCH_STAGES; j++) begin : g_stage
      localparam int K = SEARCH_STAGES - 1 - j;
      logic [SRCH_W-1:0] p_prev, q_prev, trial;
      logic [DIST_W-1:0] d_prev;
      logic [SQ_W-1:0]   s_prev;
      logic [NORM_W-1:0] n_prev;
      logic              g_prev, take;

      if (j == 0) begin : g_first
         assign p_prev = '0;
         assign q_prev = '0;
         assign d_prev = '0;
         assign s_prev = sq;
         assign n_prev = norm;
         assign g_prev = deg_i;
      end else begin : g_next
         assign p_prev = p_ff[j-1];
         assign q_prev = q_ff[j-1];
         assign d_prev = d_ff[j-1];
         assign s_prev = s_ff[j-1];
         assign n_prev = n_ff[j-1];
         assign g_prev = g_ff[j-1];
      end

      // (d + 2^k)^2 n = d^2 n + 2^(k+1) d n + 2^(2k) n
      assign trial = p_prev + (q_prev << (K+1)) + (SRCH_W'(n_prev) << (2*K));
      assign take  = (trial <= SRCH_W'(s_prev));

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[j] <= take ? trial : p_prev;
            q_ff[j] <= take ? q_prev + (SRCH_W'(n_prev) << K) : q_prev;
            d_ff[j] <= take ? (d_prev | (DIST_W'(1) << K)) : d_prev;
            s_ff[j] <= s_prev;
            n_ff[j] <= n_prev;
            g_ff[j] <= g_prev;
         end
      end
   end

   assign dist_o = d_ff[SEARCH_STAGES-1];
   assign deg_o  = g_ff[SEARCH_STAGES-1];

endmodule

@@ tb/epipolar_distance_checker.sv @@
// ----------------------------------------------------------------------------
// epipolar distance checker
// watches the req, rsp and csr channels of the core, works out the expected
// distance and degenerate flag for each accepted req word and compares them
// in order with the rsp words
// ----------------------------------------------------------------------------
module epipolar_distance_checker
   import edc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [4*PT_W-1:0]    req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [DIST_W-1:0]    rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DIST_W-1:0] max_dist;
      logic              deg;
   } distance_type;

   logic [REG_W-1:0] f21_rows [3];
   logic [REG_W-1:0] f12_rows [3];
   distance_type     expected_q [$];

   function automatic longint coef(input logic [REG_W-1:0] row, input int k);
      logic signed [COEF_W-1:0] c;
      c = row[k*COEF_W +: COEF_W];
      return c;
   endfunction

   // one line term at scale 2^23
   function automatic longint line_term(input logic [REG_W-1:0] row,
                                        input longint x, input longint y);
      return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * 16;
   endfunction

   // floor(|a*x + b*y + 16c| / sqrt(a*a + b*b)), capped at 16 bits
   function automatic logic [DIST_W-1:0] point_dist(input longint a, input longint b,
                                                    input longint c, input longint x,
                                                    input longint y, inout logic deg);
      logic [127:0] nrm, sq, t;
      logic [63:0]  am, bm, dm;
      logic [DIST_W-1:0] d;
      longint dot;
      int i;
      am = (a < 0) ? -a : a;
      bm = (b < 0) ? -b : b;
      nrm = {64'b0, am} * {64'b0, am} + {64'b0, bm} * {64'b0, bm};
      if (nrm == 0) begin
         deg = 1'b1;
         return '1;
      end
      dot = x * a + y * b + c * 16;
      dm = (dot < 0) ? -dot : dot;
      sq = {64'b0, dm} * {64'b0, dm};
      d = '0;
      for (i = DIST_W - 1; i >= 0; i--) begin
         t = {112'b0, d | (16'h1 << i)};
         if (t * t * nrm <= sq) d = d | (16'h1 << i);
      end
      return d;
   endfunction

   function automatic distance_type predict_distance(input logic [4*PT_W-1:0] pts);
      longint x1, y1, x2, y2;
      longint l1 [3];
      longint l2 [3];
      logic [DIST_W-1:0] d1, d2;
      distance_type r;
      int i;
      x1 = pts[0 +: PT_W];
      y1 = pts[PT_W +: PT_W];
      x2 = pts[2*PT_W +: PT_W];
      y2 = pts[3*PT_W +: PT_W];
      for (i = 0; i < 3; i++) begin
         l1[i] = line_term(f12_rows[i], x2, y2);
         l2[i] = line_term(f21_rows[i], x1, y1);
      end
      r.deg = 1'b0;
      d1 = point_dist(l1[0], l1[1], l1[2], x1, y1, r.deg);
      d2 = point_dist(l2[0], l2[1], l2[2], x2, y2, r.deg);
      r.max_dist = r.deg ? '1 : ((d1 > d2) ? d1 : d2);
      return r;
   endfunction

   always @(posedge clock) begin
      distance_type exp_d;
      int errs;
      errs = 0;
      if (reset) begin
         foreach (f21_rows[i]) f21_rows[i] <= '0;
         foreach (f12_rows[i]) f12_rows[i] <= '0;
         expected_q.delete();
         pending <= 0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_F21_ROW0: f21_rows[0] <= csr_data;
               CSR_F21_ROW1: f21_rows[1] <= csr_data;
               CSR_F21_ROW2: f21_rows[2] <= csr_data;
               CSR_F12_ROW0: f12_rows[0] <= csr_data;
               CSR_F12_ROW1: f12_rows[1] <= csr_data;
               CSR_F12_ROW2: f12_rows[2] <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_q = {expected_q, predict_distance(req_tdata)};
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("rsp word with no expected result: max_distance %0d degenerate %0d",
                      rsp_tdata, rsp_tuser);
               errs++;
            end else begin
               exp_d = expected_q.pop_front();
               if (exp_d.max_dist !== rsp_tdata) begin
                  $error("max_distance expected %0d actual %0d", exp_d.max_dist, rsp_tdata);
                  errs++;
               end
               if (exp_d.deg !== rsp_tuser) begin
                  $error("degenerate expected %0d actual %0d", exp_d.deg, rsp_tuser);
                  errs++;
               end
            end
         end
         pending <= expected_q.size();
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

@@ tb/tb_epipolar_distance_check_core.sv @@
// ----------------------------------------------------------------------------
// tb_epipolar_distance_check_core
// drives point pairs and matrix settings into the core under random idling
// on both sides; the checker predicts and compares every rsp word
// ----------------------------------------------------------------------------
module tb_epipolar_distance_check_core
   import edc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_SET = 110;
   localparam int NUM_KINDS = 5;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [4*PT_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DIST_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_data = '0;
   int                   fail_count;
   int                   pending;

   int sender_idle_pct = 28;
   int receiver_stall_pct = 72;
   int cycles = 0;
   int words_sent = 0;
   int reg_writes = 0;
   logic [REG_W-1:0] f21 [3];
   logic [REG_W-1:0] f12 [3];

   epipolar_distance_check_core u_top (.*);

   epipolar_distance_checker u_checker (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
   endtask

   task automatic load_matrices();
      // an index past the register list must leave everything unchanged
      if ($urandom_range(3) == 0)
         write_reg(CSR_IDX_W'(NUM_REGS + $urandom_range(1)), REG_W'({$urandom, $urandom}));
      write_reg(CSR_F21_ROW0, f21[0]);
      write_reg(CSR_F21_ROW1, f21[1]);
      write_reg(CSR_F21_ROW2, f21[2]);
      write_reg(CSR_F12_ROW0, f12[0]);
      write_reg(CSR_F12_ROW1, f12[1]);
      write_reg(CSR_F12_ROW2, f12[2]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_points(input logic [PT_W-1:0] x1, input logic [PT_W-1:0] y1,
                              input logic [PT_W-1:0] x2, input logic [PT_W-1:0] y2);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y2, x2, y1, x1};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
   endtask

   function automatic logic [REG_W-1:0] pack_row(input logic [COEF_W-1:0] c0,
                                                 input logic [COEF_W-1:0] c1,
                                                 input logic [COEF_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   // pure shift in y: both lines horizontal, distance is |y2 - y1|
   task automatic make_shift(input logic [COEF_W-1:0] c);
      f12[0] = '0;
      f12[1] = pack_row('0, '0, -c);
      f12[2] = pack_row('0, c, '0);
      f21[0] = '0;
      f21[1] = pack_row('0, '0, c);
      f21[2] = pack_row('0, -c, '0);
   endtask

   function automatic logic [COEF_W-1:0] extreme_coef();
      return $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
   endfunction

   task automatic make_config(input int kind);
      logic [COEF_W-1:0] c;
      int i;
      c = COEF_W'($urandom_range(1, 21'h0FFFFF));
      if ($urandom_range(1)) c = -c;
      for (i = 0; i < 3; i++) begin
         case (kind)
            1: begin
               f21[i] = REG_W'({$urandom, $urandom});
               f12[i] = REG_W'({$urandom, $urandom});
            end
            2: begin
               f21[i] = pack_row(21'($signed($urandom_range(255)) - 128),
                                 21'($signed($urandom_range(255)) - 128),
                                 21'($signed($urandom_range(255)) - 128));
               f12[i] = pack_row(21'($signed($urandom_range(255)) - 128),
                                 21'($signed($urandom_range(255)) - 128),
                                 21'($signed($urandom_range(255)) - 128));
            end
            3: begin
               f21[i] = pack_row(extreme_coef(), extreme_coef(), extreme_coef());
               f12[i] = pack_row(extreme_coef(), extreme_coef(), extreme_coef());
            end
            4: begin
               // first two rows zero: every line from point two is degenerate
               f21[i] = REG_W'({$urandom, $urandom});
               f12[i] = (i == 2) ? REG_W'({$urandom, $urandom}) : '0;
            end
            default: ;
         endcase
      end
      if (kind == 0) make_shift(c);
   endtask

   task automatic send_random(input int kind);
      logic [PT_W-1:0] x1, y1, x2, y2;
      x1 = PT_W'($urandom);
      y1 = PT_W'($urandom);
      x2 = PT_W'($urandom);
      y2 = PT_W'($urandom);
      if ($urandom_range(9) == 0) begin
         x1 = $urandom_range(1) ? '1 : '0;
         y2 = $urandom_range(1) ? '1 : '0;
      end
      // mostly near matches so the distances stay small
      if (kind == 0 && $urandom_range(9) < 8) y2 = y1 + PT_W'($urandom_range(128)) - 16'd64;
      send_points(x1, y1, x2, y2);
   endtask

   initial begin
      int m, k, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all registers zero after reset: every word is degenerate
      send_points('0, '0, '0, '0);
      send_points('1, '1, '1, '1);
      drain();

      make_shift(21'h0FFFFF);
      load_matrices();
      send_points('0, '0, '0, '0);
      send_points('1, '0, '0, '1);
      send_points('0, '1, '1, '0);
      send_points(16'h1234, 16'h8000, 16'h4321, 16'h8010);
      drain();

      make_shift(21'h100000);
      load_matrices();
      send_points('1, '1, '1, '1);
      send_points('0, 16'h0001, '1, '0);
      drain();

      f21[0] = pack_row(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF);
      f21[1] = pack_row(21'h100000, 21'h100000, 21'h100000);
      f21[2] = pack_row(21'h0FFFFF, 21'h100000, 21'h0FFFFF);
      f12 = f21;
      load_matrices();
      send_points('1, '1, '1, '1);
      send_points('0, '0, '0, '0);
      send_points('1, '0, '0, '1);
      drain();

      make_config(4);
      load_matrices();
      send_points('0, '0, '0, '0);
      send_points('1, '1, '1, '1);
      send_points(16'h0100, 16'h0200, 16'h0300, 16'h0400);
      drain();

      for (m = 0; m < 3; m++) begin
         sender_idle_pct    = (m == 0) ? 28 : (m == 1) ? 72 : 0;
         receiver_stall_pct = (m == 0) ? 72 : (m == 1) ? 28 : 0;
         for (k = 0; k < NUM_KINDS; k++) begin
            make_config(k);
            load_matrices();
            for (n = 0; n < ITEMS_PER_SET; n++) send_random(k);
            drain();
         end
      end

      $display("covered %0d point pairs over %0d register writes,", words_sent, reg_writes);
      $display("shift, random, small, extreme and degenerate matrices under three idle mixes");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
